/* rtl/ttb_pkg.sv */
// Shared types and helpers for the triangle tangent/binormal block.
// Used by every module of the block; no dependencies.
package ttb_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int OUT_W   = 16;
   localparam int VAL_W   = 66;
   localparam int QDEPTH  = 2;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [VAL_W-1:0]  val_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
      logic signed [COORD_W-1:0] tex_u;
      logic signed [COORD_W-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic signed [OUT_W-1:0] binormal_x;
      logic signed [OUT_W-1:0] binormal_y;
      logic signed [OUT_W-1:0] binormal_z;
      logic                    degenerate;
   } rsp_type;

   // edge vectors and UV deltas of one triangle, all exact
   typedef struct packed {
      diff_type [2:0] e1;
      diff_type [2:0] e2;
      diff_type       du1;
      diff_type       dv1;
      diff_type       du2;
      diff_type       dv2;
   } job_type;

   // queue handshake between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic diff_type coord_diff(logic signed [COORD_W-1:0] a,
                                           logic signed [COORD_W-1:0] b);
      coord_diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
   endfunction

endpackage

/* rtl/triangle_tangent_binormal_top.sv */
// Top level of the triangle tangent/binormal block.
// Depends on ttb_pkg, ttb_front, ttb_queue and ttb_back.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  one vertex, Q16.16 x,y,z,u,v
//   rsp_     out        rsp_valid/rsp_stall  one triangle, Q1.14 T and B, degenerate
//
// A vertex beat is taken whenever the two-entry job queue has room.
// Each triangle runs a multiply/accumulate sequence (one shared 32x32 multiplier),
// then per vector a shift normalization, squaring, 32 square-root steps and
// 3 bit-serial divisions.
// Reset clears the vertex slot, the queue and the back-end state machine.
// A stalled result waits in the output register; the front keeps filling the queue.
module triangle_tangent_binormal_top
   import ttb_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   qstat_type qstat;
   logic      push, pop;
   job_type   push_job, pop_job;

   // vertex slot tracking and edge/UV differences
   ttb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .job       (push_job)
   );

   // decouples vertex intake from the long arithmetic sequence
   ttb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .qstat     (qstat)
   );

   ttb_back #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .job       (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("job popped from empty queue");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.tangent_x == '0 && rsp_data.tangent_y == '0 &&
          rsp_data.tangent_z == '0 && rsp_data.binormal_x == '0 &&
          rsp_data.binormal_y == '0 && rsp_data.binormal_z == '0))
      else $error("degenerate result with nonzero vectors");
`endif

endmodule

/* rtl/ttb_front.sv */
// Front end: tracks the vertex slot, holds two vertices, emits a triangle job.
// Depends on ttb_pkg.
module ttb_front
   import ttb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  qstat_type qstat,
   output logic      push,
   output job_type   job
);

   logic [1:0] slot_ff;
   req_type    hold0_ff;
   req_type    hold1_ff;
   logic       accept;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign push      = accept && (slot_ff == 2'd2);

   assign job.e1[0] = coord_diff(hold1_ff.vertex_x, hold0_ff.vertex_x);
   assign job.e1[1] = coord_diff(hold1_ff.vertex_y, hold0_ff.vertex_y);
   assign job.e1[2] = coord_diff(hold1_ff.vertex_z, hold0_ff.vertex_z);
   assign job.e2[0] = coord_diff(req_data.vertex_x, hold0_ff.vertex_x);
   assign job.e2[1] = coord_diff(req_data.vertex_y, hold0_ff.vertex_y);
   assign job.e2[2] = coord_diff(req_data.vertex_z, hold0_ff.vertex_z);
   assign job.du1   = coord_diff(hold1_ff.tex_u, hold0_ff.tex_u);
   assign job.dv1   = coord_diff(hold1_ff.tex_v, hold0_ff.tex_v);
   assign job.du2   = coord_diff(req_data.tex_u, hold0_ff.tex_u);
   assign job.dv2   = coord_diff(req_data.tex_v, hold0_ff.tex_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else if (accept) begin
         unique case (slot_ff)
            2'd1: begin
               hold1_ff <= req_data;
               slot_ff  <= 2'd2;
            end
            2'd2: begin
               slot_ff <= 2'd0;
            end
            default: begin
               hold0_ff <= req_data;
               slot_ff  <= 2'd1;
            end
         endcase
      end
   end

endmodule

/* rtl/ttb_queue.sv */
// Two-entry job queue between the front end and the arithmetic back end.
// Depends on ttb_pkg.
module ttb_queue
   import ttb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_data,
   input  logic      pop,
   output job_type   pop_data,
   output qstat_type qstat
);

   localparam int PTR_W = $clog2(QDEPTH);

   job_type            mem_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;

   assign qstat.full  = (count_ff == (PTR_W+1)'(QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/ttb_back.sv */
// Back end: sequenced multiply, normalize, square root and divide per triangle.
// Depends on ttb_pkg.
module ttb_back
   import ttb_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   input  qstat_type qstat,
   input  job_type   job,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int DW    = OUT_FRAC_BITS + 31;
   localparam int CNT_W = $clog2(DW + 1);

   typedef enum logic [3:0] {
      IDLE, MUL_A, MUL_B, ACC, CHECK, VLOAD, NORM, SQ, ROOT, DIV_LOAD, DIV, STORE, EMIT
   } state_type;

   state_type          state_ff;
   job_type            job_ff;
   val_type            val_ff [7];
   logic [2:0]         j_ff;
   logic [63:0]        pa_ff, pb_ff;
   logic               sa_ff, sb_ff;
   logic               vec_ff;
   logic [64:0]        c_ff [3];
   logic               neg_ff [3];
   logic [63:0]        s_ff, res_ff, bit_ff;
   logic [59:0]        sq_ff;
   logic [1:0]         idx_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DW-1:0]      dvd_ff;
   logic [31:0]        rem_ff, len_ff;
   logic [15:0]        quo_ff;
   logic [15:0]        to_ff [3];
   logic [15:0]        bo_ff [3];
   logic               deg_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   function automatic logic [31:0] mag33(diff_type x);
      diff_type n;
      n = x[DIFF_W-1] ? -x : x;
      mag33 = n[31:0];
   endfunction

   function automatic logic [64:0] mag66(val_type x);
      val_type n;
      n = x[VAL_W-1] ? -x : x;
      mag66 = n[64:0];
   endfunction

   function automatic val_type sval(logic [63:0] p, logic s);
      val_type v;
      v = {2'b00, p};
      sval = s ? -v : v;
   endfunction

   // operand select for value j: A*B - C*D
   diff_type op_a, op_b, op_c, op_d, op_1, op_2;
   always_comb begin
      op_a = job_ff.du1; op_b = job_ff.dv2; op_c = job_ff.du2; op_d = job_ff.dv1;
      unique case (j_ff)
         3'd1, 3'd2, 3'd3: begin
            op_a = job_ff.dv2; op_b = job_ff.e1[j_ff[1:0] - 2'd1];
            op_c = job_ff.dv1; op_d = job_ff.e2[j_ff[1:0] - 2'd1];
         end
         3'd4: begin
            op_a = job_ff.du1; op_b = job_ff.e2[0]; op_c = job_ff.du2; op_d = job_ff.e1[0];
         end
         3'd5: begin
            op_a = job_ff.du1; op_b = job_ff.e2[1]; op_c = job_ff.du2; op_d = job_ff.e1[1];
         end
         3'd6: begin
            op_a = job_ff.du1; op_b = job_ff.e2[2]; op_c = job_ff.du2; op_d = job_ff.e1[2];
         end
         default: ;
      endcase
      op_1 = (state_ff == MUL_B) ? op_c : op_a;
      op_2 = (state_ff == MUL_B) ? op_d : op_b;
   end

   logic [63:0] prod;
   logic        prod_sgn;
   assign prod     = mag33(op_1) * mag33(op_2);
   assign prod_sgn = op_1[DIFF_W-1] ^ op_2[DIFF_W-1];

   // vector operands for the current normalization pass
   val_type vsel [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsel[i] = vec_ff ? val_ff[4+i] : val_ff[1+i];
      end
   end

   logic [64:0] m0, m1, m2, c_or;
   logic        any_hi;
   assign m0     = mag66(vsel[0]);
   assign m1     = mag66(vsel[1]);
   assign m2     = mag66(vsel[2]);
   assign c_or   = c_ff[0] | c_ff[1] | c_ff[2];
   assign any_hi = |c_or[64:30];

   logic [29:0] c_cur;
   always_comb begin
      unique case (idx_ff)
         2'd1:    c_cur = c_ff[1][29:0];
         2'd2:    c_cur = c_ff[2][29:0];
         default: c_cur = c_ff[0][29:0];
      endcase
   end

   logic [63:0] trial;
   logic [32:0] r2;
   logic        ge;
   logic [15:0] q16;
   assign trial = res_ff + bit_ff;
   assign r2    = {rem_ff, dvd_ff[DW-1]};
   assign ge    = (r2 >= {1'b0, len_ff});
   assign q16   = neg_ff[idx_ff] ? (16'd0 - quo_ff) : quo_ff;

   assign pop       = (state_ff == IDLE) && !qstat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // EMIT owns the valid flag while it is loading the next result
         if (rsp_valid_ff && !rsp_stall && state_ff != EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (!qstat.empty) begin
                  job_ff   <= job;
                  j_ff     <= 3'd0;
                  state_ff <= MUL_A;
               end
            end
            MUL_A: begin
               pa_ff    <= prod;
               sa_ff    <= prod_sgn;
               state_ff <= MUL_B;
            end
            MUL_B: begin
               pb_ff    <= prod;
               sb_ff    <= prod_sgn;
               state_ff <= ACC;
            end
            ACC: begin
               val_ff[j_ff] <= sval(pa_ff, sa_ff) - sval(pb_ff, sb_ff);
               if (j_ff == 3'd6) begin
                  state_ff <= CHECK;
               end else begin
                  j_ff     <= j_ff + 3'd1;
                  state_ff <= MUL_A;
               end
            end
            CHECK: begin
               vec_ff <= 1'b0;
               if (val_ff[0] == '0) begin
                  deg_ff   <= 1'b1;
                  state_ff <= EMIT;
               end else begin
                  state_ff <= VLOAD;
               end
            end
            VLOAD: begin
               c_ff[0]   <= m0;
               c_ff[1]   <= m1;
               c_ff[2]   <= m2;
               neg_ff[0] <= vsel[0][VAL_W-1] ^ val_ff[0][VAL_W-1];
               neg_ff[1] <= vsel[1][VAL_W-1] ^ val_ff[0][VAL_W-1];
               neg_ff[2] <= vsel[2][VAL_W-1] ^ val_ff[0][VAL_W-1];
               if ((m0 | m1 | m2) == '0) begin
                  deg_ff   <= 1'b1;
                  state_ff <= EMIT;
               end else begin
                  state_ff <= NORM;
               end
            end
            NORM: begin
               // bring the largest magnitude to exactly 30 bits
               if (any_hi) begin
                  for (int i = 0; i < 3; i++) c_ff[i] <= c_ff[i] >> 1;
               end else if (!c_or[29]) begin
                  for (int i = 0; i < 3; i++) c_ff[i] <= c_ff[i] << 1;
               end else begin
                  s_ff     <= '0;
                  idx_ff   <= 2'd0;
                  state_ff <= SQ;
               end
            end
            SQ: begin
               if (idx_ff != 2'd0) begin
                  s_ff <= s_ff + {4'd0, sq_ff};
               end
               if (idx_ff == 2'd3) begin
                  res_ff   <= '0;
                  bit_ff   <= 64'd1 << 62;
                  state_ff <= ROOT;
               end else begin
                  sq_ff  <= c_cur * c_cur;
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            ROOT: begin
               if (s_ff >= trial) begin
                  s_ff   <= s_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  len_ff   <= (s_ff >= trial) ? 32'((res_ff >> 1) + bit_ff)
                                              : 32'(res_ff >> 1);
                  idx_ff   <= 2'd0;
                  state_ff <= DIV_LOAD;
               end
            end
            DIV_LOAD: begin
               dvd_ff   <= (DW'(c_cur) << OUT_FRAC_BITS) + DW'(len_ff >> 1);
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               rem_ff <= ge ? 32'(r2 - {1'b0, len_ff}) : r2[31:0];
               quo_ff <= {quo_ff[14:0], ge};
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DW - 1)) begin
                  state_ff <= STORE;
               end
            end
            STORE: begin
               if (vec_ff) bo_ff[idx_ff] <= q16;
               else        to_ff[idx_ff] <= q16;
               if (idx_ff == 2'd2) begin
                  if (vec_ff) begin
                     deg_ff   <= 1'b0;
                     state_ff <= EMIT;
                  end else begin
                     vec_ff   <= 1'b1;
                     state_ff <= VLOAD;
                  end
               end else begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= DIV_LOAD;
               end
            end
            EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.tangent_x  <= deg_ff ? '0 : to_ff[0];
                  rsp_ff.tangent_y  <= deg_ff ? '0 : to_ff[1];
                  rsp_ff.tangent_z  <= deg_ff ? '0 : to_ff[2];
                  rsp_ff.binormal_x <= deg_ff ? '0 : bo_ff[0];
                  rsp_ff.binormal_y <= deg_ff ? '0 : bo_ff[1];
                  rsp_ff.binormal_z <= deg_ff ? '0 : bo_ff[2];
                  rsp_ff.degenerate <= deg_ff;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for triangle_tangent_binormal_top: streams vertex beats, predicts the tangent
// and binormal of each triangle in fixed point and checks every result beat in order.
// Depends on rtl/ttb_pkg.sv and rtl/triangle_tangent_binormal_top.sv.
module testbench;
   import ttb_pkg::*;

   localparam int FRAC_BITS   = 14;
   localparam int WATCHDOG    = 20000;  // cycles with no beat on either side
   localparam int SETTLE_CYC  = 600;    // longer than one triangle's worst latency
   localparam int ONE         = 32'h0001_0000;  // 1.0 in Q16.16

   typedef logic signed [69:0] acc_t;  // exact products and their differences

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // idling knobs, percent of cycles
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;

   // predictor state: first two vertices of the open triangle and where we are in it
   req_type held_corner [2];
   int      corner_slot = 0;

   rsp_type pending_bases [$];
   int      error_count = 0;
   int      vertices_sent = 0;
   int      triangles_checked = 0;
   int      degenerate_seen = 0;
   int      quiet_cycles = 0;

   triangle_tangent_binormal_top #(.OUT_FRAC_BITS(FRAC_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------

   // isqrt by the classic bit-pair method, floor result
   function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
      logic [63:0] root;
      logic [63:0] bitpos;
      root = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > s) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (s >= root + bitpos) begin
            s = s - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // Normalize one exact vector. Components are scaled together so the largest
   // magnitude has 30 significant bits (right shift truncates), then divided by
   // the floored length with round-half-up. Returns 0 for a zero vector.
   function automatic bit unit_axis(input acc_t v [3], input bit flip,
                                    output logic [15:0] o [3]);
      logic [69:0] mag [3];
      bit          neg [3];
      logic [63:0] c [3];
      logic [63:0] sum_sq;
      logic [63:0] len;
      logic [63:0] q;
      int          top;
      top = 0;
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         neg[i] = neg[i] ^ flip;
         for (int b = 69; b >= 0; b--)
            if (mag[i][b] && b + 1 > top) top = b + 1;
      end
      for (int i = 0; i < 3; i++) o[i] = '0;
      if (top == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (top > 30) c[i] = 64'(mag[i] >> (top - 30));
         else          c[i] = 64'(mag[i] << (30 - top));
         sum_sq = sum_sq + c[i] * c[i];
      end
      len = floor_sqrt(sum_sq);
      for (int i = 0; i < 3; i++) begin
         q = ((c[i] << FRAC_BITS) + (len >> 1)) / len;
         o[i] = neg[i] ? 16'(-q) : q[15:0];
      end
      return 1'b1;
   endfunction

   function automatic logic signed [32:0] coord_delta(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
      return $signed({a[31], a}) - $signed({b[31], b});
   endfunction

   // Tangent frame of one triangle from its three vertices.
   function automatic rsp_type triangle_basis(input req_type p0, input req_type p1,
                                              input req_type p2);
      logic signed [32:0] e1 [3];
      logic signed [32:0] e2 [3];
      logic signed [32:0] du1, dv1, du2, dv2;
      acc_t               det;
      acc_t               tan_v [3];
      acc_t               bin_v [3];
      logic [15:0]        tan_o [3];
      logic [15:0]        bin_o [3];
      bit                 ok;
      rsp_type            r;
      e1[0] = coord_delta(p1.vertex_x, p0.vertex_x);
      e1[1] = coord_delta(p1.vertex_y, p0.vertex_y);
      e1[2] = coord_delta(p1.vertex_z, p0.vertex_z);
      e2[0] = coord_delta(p2.vertex_x, p0.vertex_x);
      e2[1] = coord_delta(p2.vertex_y, p0.vertex_y);
      e2[2] = coord_delta(p2.vertex_z, p0.vertex_z);
      du1 = coord_delta(p1.tex_u, p0.tex_u);
      dv1 = coord_delta(p1.tex_v, p0.tex_v);
      du2 = coord_delta(p2.tex_u, p0.tex_u);
      dv2 = coord_delta(p2.tex_v, p0.tex_v);
      det = acc_t'(du1) * acc_t'(dv2) - acc_t'(du2) * acc_t'(dv1);
      for (int i = 0; i < 3; i++) begin
         tan_v[i] = acc_t'(dv2) * acc_t'(e1[i]) - acc_t'(dv1) * acc_t'(e2[i]);
         bin_v[i] = acc_t'(du1) * acc_t'(e2[i]) - acc_t'(du2) * acc_t'(e1[i]);
      end
      ok = det != 0;
      if (ok) ok = unit_axis(tan_v, det < 0, tan_o);
      if (ok) ok = unit_axis(bin_v, det < 0, bin_o);
      r = '0;
      if (ok) begin
         r.tangent_x  = tan_o[0];
         r.tangent_y  = tan_o[1];
         r.tangent_z  = tan_o[2];
         r.binormal_x = bin_o[0];
         r.binormal_y = bin_o[1];
         r.binormal_z = bin_o[2];
      end
      r.degenerate = !ok;
      return r;
   endfunction

   // called once per accepted vertex beat
   function automatic void absorb_vertex(input req_type v);
      if (corner_slot < 2) begin
         held_corner[corner_slot] = v;
         corner_slot++;
      end else begin
         pending_bases.push_back(triangle_basis(held_corner[0], held_corner[1], v));
         corner_slot = 0;
      end
   endfunction

   // --------------------------------------------------------------------
   // Driving
   // --------------------------------------------------------------------

   // One vertex beat. Valid stays high across back-to-back calls unless the sender idles;
   // stall is sampled at the falling edge, where it is settled for the next rising one.
   task automatic send_vertex(input req_type v);
      bit taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      absorb_vertex(v);
      vertices_sent++;
   endtask

   task automatic hold_sender;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_drain;
      hold_sender();
      while (pending_bases.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_vertex(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z, input logic [31:0] u,
                                           input logic [31:0] v);
      req_type r;
      r.vertex_x = x;
      r.vertex_y = y;
      r.vertex_z = z;
      r.tex_u    = u;
      r.tex_v    = v;
      return r;
   endfunction

   // full range half the time, otherwise a modest mesh-like range
   function automatic logic [31:0] random_coord(input bit wide);
      if (wide) return $urandom;
      return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   task automatic send_random_triangle;
      req_type     tri_v [3];
      bit          wide;
      int          flavor;
      logic [31:0] shared_u, shared_v;
      wide = $urandom_range(1);
      flavor = $urandom_range(99);
      shared_u = random_coord(wide);
      shared_v = random_coord(wide);
      for (int k = 0; k < 3; k++) begin
         tri_v[k] = make_vertex(random_coord(wide), random_coord(wide), random_coord(wide),
                                random_coord(wide), random_coord(wide));
         // a few degenerate shapes: repeated UVs, or every corner on one spot
         if (flavor < 4) begin
            tri_v[k].tex_u = shared_u;
            tri_v[k].tex_v = shared_v;
         end else if (flavor < 7 && k > 0) begin
            tri_v[k].vertex_x = tri_v[0].vertex_x;
            tri_v[k].vertex_y = tri_v[0].vertex_y;
            tri_v[k].vertex_z = tri_v[0].vertex_z;
         end
      end
      for (int k = 0; k < 3; k++) send_vertex(tri_v[k]);
   endtask

   // --------------------------------------------------------------------
   // Receiving and checking
   // --------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch on triangle %0d: %s got %h, expected %h",
               triangles_checked, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bases.size() == 0) begin
            $display("result beat with no triangle outstanding");
            error_count++;
         end else begin
            want = pending_bases.pop_front();
            if (rsp_data.tangent_x !== want.tangent_x)
               report_mismatch("tangent_x", rsp_data.tangent_x, want.tangent_x);
            if (rsp_data.tangent_y !== want.tangent_y)
               report_mismatch("tangent_y", rsp_data.tangent_y, want.tangent_y);
            if (rsp_data.tangent_z !== want.tangent_z)
               report_mismatch("tangent_z", rsp_data.tangent_z, want.tangent_z);
            if (rsp_data.binormal_x !== want.binormal_x)
               report_mismatch("binormal_x", rsp_data.binormal_x, want.binormal_x);
            if (rsp_data.binormal_y !== want.binormal_y)
               report_mismatch("binormal_y", rsp_data.binormal_y, want.binormal_y);
            if (rsp_data.binormal_z !== want.binormal_z)
               report_mismatch("binormal_z", rsp_data.binormal_z, want.binormal_z);
            if (rsp_data.degenerate !== want.degenerate)
               report_mismatch("degenerate", 16'(rsp_data.degenerate), 16'(want.degenerate));
            if (want.degenerate) degenerate_seen++;
         end
         triangles_checked++;
      end
   end

   // watchdog: any beat on either channel resets the count
   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no beat for %0d cycles, %0d triangles outstanding",
                     WATCHDOG, pending_bases.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // unit axes, a flipped UV winding, the extremes of every field, and tiny edges
   task automatic test_directed_shapes;
      send_vertex(make_vertex(0, 0, 0, 0, 0));
      send_vertex(make_vertex(ONE, 0, 0, ONE, 0));
      send_vertex(make_vertex(0, ONE, 0, 0, ONE));
      // negative determinant flips both vectors
      send_vertex(make_vertex(0, 0, 0, 0, 0));
      send_vertex(make_vertex(ONE, 0, 0, -ONE, 0));
      send_vertex(make_vertex(0, 0, ONE, 0, ONE));
      send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000));
      send_vertex(make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff));
      send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff));
      send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              32'h8000_0000, 32'h8000_0000));
      send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                              32'h7fff_ffff, 32'h8000_0000));
      send_vertex(make_vertex(32'hffff_ffff, 1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
      // tiny edges: left-shift path of the normalizer
      send_vertex(make_vertex(5, 5, 5, 5, 5));
      send_vertex(make_vertex(6, 5, 5, 6, 5));
      send_vertex(make_vertex(5, 7, 4, 5, 6));
   endtask

   // zero determinant, zero tangent/binormal, all-zero triangle
   task automatic test_degenerate_shapes;
      send_vertex(make_vertex(0, 0, 0, ONE, ONE));
      send_vertex(make_vertex(ONE, 0, 0, ONE, ONE));
      send_vertex(make_vertex(0, ONE, 0, ONE, ONE));
      send_vertex(make_vertex(ONE, ONE, ONE, 0, 0));
      send_vertex(make_vertex(ONE, ONE, ONE, ONE, 0));
      send_vertex(make_vertex(ONE, ONE, ONE, 0, ONE));
      send_vertex(make_vertex(0, 0, 0, 0, 0));
      send_vertex(make_vertex(0, 0, 0, 0, 0));
      send_vertex(make_vertex(0, 0, 0, 0, 0));
   endtask

   task automatic test_random_phase(input int triangles, input int idle_pct,
                                    input int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < triangles; n++) begin
         send_random_triangle();
         // stop mid-phase until the block is empty, then resume
         if (n == triangles / 2 && idle_pct == 0 && stall_pct == 0) wait_for_drain();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   // two vertices that never close a triangle must produce nothing
   task automatic test_leftover_vertices;
      send_vertex(make_vertex($urandom, $urandom, $urandom, $urandom, $urandom));
      send_vertex(make_vertex($urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   initial begin
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_shapes();
      test_degenerate_shapes();
      test_random_phase(100, 0, 0);
      test_random_phase(100, 88, 0);
      test_random_phase(100, 0, 88);
      test_random_phase(100, 9, 9);
      test_leftover_vertices();

      hold_sender();
      while (pending_bases.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      $display("covered %0d vertex beats and %0d triangle results, %0d of them degenerate,",
               vertices_sent, triangles_checked, degenerate_seen);
      $display("over free-running, sender-idle, receiver-stall and mixed phases");
      if (error_count == 0 && pending_bases.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
